[src/expiring_event_dedup_table_assert.svh]
// Assertion macros for the expiring event dedup table.
`ifndef EXPIRING_EVENT_DEDUP_TABLE_ASSERT_SVH
`define EXPIRING_EVENT_DEDUP_TABLE_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define EEDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define EEDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/eedt_pkg.sv]
// Package: sizes, entry layout and control structs of the event dedup table.
`timescale 1ns / 1ps
`default_nettype none
package eedt_pkg;

    localparam int CAPACITY   = 16;
    localparam int ID_BITS    = 16;
    localparam int PID_W      = 16;
    localparam int TIME_W     = 48;
    localparam int INTERVAL_W = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [INTERVAL_W-1:0] EXPIRY_RESET = INTERVAL_W'(5000000);

    // One stored partner entry
    typedef struct packed {
        logic [ID_BITS-1:0] partner;
        logic               last_kind;
        logic [TIME_W-1:0]  expiry;
    } t_entry;

    // Result handed from the sweep to the output register
    typedef struct packed {
        logic valid;
        logic accepted;
        logic insert_dropped;
    } t_res_push;

    // Sweep status seen by the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } t_sweep_stat;

endpackage
`default_nettype wire

[src/eedt_if.sv]
// Channel interfaces: event input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface eedt_evt_if;
    import eedt_pkg::*;
    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  partner_id;
    logic              event_kind;
    logic [TIME_W-1:0] timestamp;
    modport source(output valid, output partner_id, output event_kind,
                   output timestamp, input ready);
    modport sink(input valid, input partner_id, input event_kind,
                 input timestamp, output ready);
endinterface

interface eedt_res_if;
    logic valid;
    logic ready;
    logic accepted;
    logic insert_dropped;
    modport source(output valid, output accepted, output insert_dropped, input ready);
    modport sink(input valid, input accepted, input insert_dropped, output ready);
endinterface

interface eedt_cfg_if;
    import eedt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[src/eedt_mem.sv]
// Entry memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module eedt_mem (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [eedt_pkg::IDX_W-1:0] i_waddr,
    input  wire eedt_pkg::t_entry   i_wdata,
    input  wire [eedt_pkg::IDX_W-1:0] i_raddr_a,
    input  wire [eedt_pkg::IDX_W-1:0] i_raddr_b,
    output eedt_pkg::t_entry        o_rdata_a,
    output eedt_pkg::t_entry        o_rdata_b
);
    import eedt_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata_a;
    t_entry r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

[src/eedt_sweep.sv]
// Sweep controller: walks the entry list, refreshes, deletes and inserts.
`timescale 1ns / 1ps
`default_nettype none
module eedt_sweep (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    eedt_evt_if.sink                      i_evt,
    input  wire [eedt_pkg::INTERVAL_W-1:0] i_expiry_interval,
    input  wire                           i_out_free,
    output eedt_pkg::t_res_push           o_push,
    output eedt_pkg::t_sweep_stat         o_stat
);
    import eedt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_INSERT = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ID_BITS-1:0] r_id;
    logic               r_kind;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_exp_new;

    logic               evt_take;
    logic [TIME_W:0]    exp_sum;
    logic [TIME_W-1:0]  exp_sat;
    logic [IDX_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   last_idx;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   idx_inc_ext;
    logic               hit;
    logic               expired;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    t_entry             wdata;
    logic [IDX_W-1:0]   raddr_a;
    t_entry             rd_a;
    t_entry             rd_b;
    t_entry             fresh;

    eedt_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (last_idx),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // no event is taken while reset is held
    assign i_evt.ready = (r_state == S_IDLE) && i_rst_n;
    assign evt_take    = i_evt.valid && i_evt.ready;

    // saturating expiry of the incoming event
    assign exp_sum = {1'b0, i_evt.timestamp}
                   + {{(TIME_W + 1 - INTERVAL_W){1'b0}}, i_expiry_interval};
    assign exp_sat = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

    // sweep index arithmetic
    assign idx_inc     = IDX_W'(r_idx + 1'b1);
    assign last_idx    = IDX_W'(r_count - 1'b1);
    assign idx_ext     = CNT_W'(r_idx);
    assign idx_inc_ext = CNT_W'(idx_ext + 1'b1);

    // compare of the entry just read
    assign hit     = (rd_a.partner == r_id);
    assign expired = (r_now > rd_a.expiry);

    assign fresh = '{partner: r_id, last_kind: r_kind, expiry: r_exp_new};

    // next state, memory access and result
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        we      = 1'b0;
        waddr   = r_idx;
        wdata   = fresh;
        raddr_a = r_idx;
        o_push  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (evt_take) begin
                    n_idx   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (idx_ext >= r_count) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (hit) begin
                    // refresh; hold here until the output register frees up
                    if (i_out_free) begin
                        we                    = 1'b1;
                        o_push.valid          = 1'b1;
                        o_push.accepted       = (rd_a.last_kind != r_kind);
                        o_push.insert_dropped = 1'b0;
                        n_state               = S_IDLE;
                    end
                end else if (expired) begin
                    // move the last entry into this slot, then look again
                    if (r_idx != last_idx) begin
                        we    = 1'b1;
                        wdata = rd_b;
                    end
                    n_count = CNT_W'(r_count - 1'b1);
                    n_state = S_READ;
                end else begin
                    n_idx = idx_inc;
                    if (idx_inc_ext >= r_count) begin
                        n_state = S_INSERT;
                    end else begin
                        raddr_a = idx_inc;
                    end
                end
            end
            S_INSERT: begin
                if (i_out_free) begin
                    o_push.valid    = 1'b1;
                    o_push.accepted = 1'b1;
                    if (r_count < CNT_W'(CAPACITY)) begin
                        we                    = 1'b1;
                        waddr                 = IDX_W'(r_count);
                        n_count               = CNT_W'(r_count + 1'b1);
                        o_push.insert_dropped = 1'b0;
                    end else begin
                        o_push.insert_dropped = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // captured event
    always_ff @(posedge i_clk) begin
        if (evt_take) begin
            r_id      <= i_evt.partner_id[ID_BITS-1:0];
            r_kind    <= i_evt.event_kind;
            r_now     <= i_evt.timestamp;
            r_exp_new <= exp_sat;
        end
    end

    assign o_stat = '{busy: (r_state != S_IDLE), count: r_count};

endmodule
`default_nettype wire

[src/expiring_event_dedup_table.sv]
// Sequence: a taken event starts a sweep that reads the entries in turn, removes expired
// ones on the way, then refreshes a matching entry or inserts a new one on a miss
// (dropped when the list is full). No new event is taken before the last one's result
// is pushed: the input stalls for the whole sweep and while a finished result waits
// behind a full result register.
// Reset (synchronous, active low): list empty, expiry interval 5000000, no result.
`timescale 1ns / 1ps
`default_nettype none
module expiring_event_dedup_table (
    input  wire        i_clk,
    input  wire        i_rst_n,
    eedt_evt_if.sink   i_evt,
    eedt_cfg_if.sink   i_cfg,
    eedt_res_if.source o_res
);
    import eedt_pkg::*;

    logic [INTERVAL_W-1:0] r_expiry_interval;
    logic                  r_out_valid;
    logic                  r_out_accepted;
    logic                  r_out_dropped;
    logic                  out_free;
    t_res_push             push;
    t_sweep_stat           stat;

    eedt_sweep u_sweep (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_evt             (i_evt),
        .i_expiry_interval (r_expiry_interval),
        .i_out_free        (out_free),
        .o_push            (push),
        .o_stat            (stat)
    );

    // configuration register
    assign i_cfg.ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry_interval <= EXPIRY_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_expiry_interval <= i_cfg.data;
        end
    end

    // result register
    assign out_free = !r_out_valid || o_res.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out_accepted <= push.accepted;
            r_out_dropped  <= push.insert_dropped;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.accepted       = r_out_accepted;
    assign o_res.insert_dropped = r_out_dropped;

    // checks
`include "expiring_event_dedup_table_assert.svh"
    `EEDT_ASSERT_NOW(a_count_cap, 1'b1, stat.count <= CNT_W'(CAPACITY), "entry count above capacity")
    `EEDT_ASSERT_NOW(a_push_free, push.valid, out_free, "result pushed into a full result register")
    `EEDT_ASSERT_NOW(a_busy_no_take, stat.busy, !i_evt.ready, "event taken during a sweep")
    `EEDT_ASSERT_NEXT(a_push_shows, push.valid, o_res.valid, "pushed result not presented")

endmodule
`default_nettype wire

[tb/expiring_event_dedup_table_test.sv]
// Testbench for the expiring event dedup table: random and directed events vs. a predictor.
`timescale 1ns / 1ps
module expiring_event_dedup_table_test;
    import eedt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_PCT    = 27;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_FIRST  = 300;
    localparam int HOLD_SECOND = 1000;
    localparam int STEADY_LO   = 600;
    localparam int STEADY_HI   = 800;
    localparam int PHASE_ITEMS = 192;
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;

    typedef enum logic {STIM_EVENT, STIM_CONFIG} t_stim_op;

    typedef struct {
        t_stim_op              op;
        logic [PID_W-1:0]      pid;
        logic                  knd;
        logic [TIME_W-1:0]     ts;
        logic [INTERVAL_W-1:0] ivl;
    } t_stim;

    typedef struct {
        logic accepted;
        logic insert_dropped;
    } t_outcome;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    eedt_evt_if evt ();
    eedt_cfg_if cfg ();
    eedt_res_if res ();

    expiring_event_dedup_table u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Pending stimulus and outcomes still owed by the block
    t_stim    stim_q[$];
    t_outcome outcome_q[$];

    // Predictor copy of the partner list and the interval register
    logic [ID_BITS-1:0]    tbl_partner [CAPACITY];
    logic                  tbl_kind    [CAPACITY];
    logic [TIME_W-1:0]     tbl_expiry  [CAPACITY];
    int unsigned           tbl_live    = 0;
    logic [INTERVAL_W-1:0] ivl_model   = EXPIRY_RESET;

    bit  evt_took  = 1'b0;
    bit  cfg_took  = 1'b0;
    int  n_sent    = 0;
    int  n_checked = 0;
    int  n_errors  = 0;
    int  n_cycles  = 0;
    int  hold_left = 0;
    int  next_hold = HOLD_FIRST;
    longint unsigned clock_ts = 0;

    always #1 clk = ~clk;

    // Sweep the predicted list for one event and return its outcome
    function automatic t_outcome dedup_predict(logic [PID_W-1:0] pid, logic knd,
                                               logic [TIME_W-1:0] ts);
        t_outcome          r;
        int unsigned       i;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] exp_new;
        sum     = {1'b0, ts} + (TIME_W+1)'(ivl_model);
        exp_new = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        r.accepted       = 1'b1;
        r.insert_dropped = 1'b0;
        i = 0;
        while (i < tbl_live) begin
            if (tbl_partner[i] == pid[ID_BITS-1:0]) begin
                tbl_expiry[i] = exp_new;
                r.accepted    = (tbl_kind[i] != knd);
                tbl_kind[i]   = knd;
                return r;
            end else if (ts > tbl_expiry[i]) begin
                // expired: last entry moves into this slot, slot is examined again
                if (i < tbl_live - 1) begin
                    tbl_partner[i] = tbl_partner[tbl_live-1];
                    tbl_kind[i]    = tbl_kind[tbl_live-1];
                    tbl_expiry[i]  = tbl_expiry[tbl_live-1];
                end
                tbl_live--;
            end else begin
                i++;
            end
        end
        if (tbl_live < CAPACITY) begin
            tbl_partner[tbl_live] = pid[ID_BITS-1:0];
            tbl_kind[tbl_live]    = knd;
            tbl_expiry[tbl_live]  = exp_new;
            tbl_live++;
        end else begin
            r.insert_dropped = 1'b1;
        end
        return r;
    endfunction

    task automatic push_event(input logic [PID_W-1:0] pid, input logic knd,
                              input logic [TIME_W-1:0] ts);
        t_stim s;
        s.op  = STIM_EVENT;
        s.pid = pid;
        s.knd = knd;
        s.ts  = ts;
        s.ivl = '0;
        stim_q = {stim_q, s};
    endtask

    task automatic push_config(input logic [INTERVAL_W-1:0] ivl);
        t_stim s;
        s.op  = STIM_CONFIG;
        s.pid = '0;
        s.knd = 1'b0;
        s.ts  = '0;
        s.ivl = ivl;
        stim_q = {stim_q, s};
    endtask

    // One interval setting followed by events from a small partner pool
    task automatic gen_phase(input logic [INTERVAL_W-1:0] ivl, input int n_items);
        logic [PID_W-1:0] pool[$];
        longint unsigned  span, inc, t, back;
        logic [PID_W-1:0] pid;
        logic [TIME_W-1:0] ts;
        int               r, pool_n;
        pool   = {16'h0000, 16'hFFFF};
        pool_n = $urandom_range(28, 10);
        repeat (pool_n) pool = {pool, PID_W'($urandom)};
        push_config(ivl);
        span = longint'({32'd0, ivl}) / 4 + 1;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 70) inc = $urandom_range(32'(span), 0);
            else if (r < 85) inc = 0;
            else inc = longint'({32'd0, ivl}) + 1 + $urandom_range(32'(span), 0);
            t = clock_ts + inc;
            clock_ts = (t > TIME_MAX) ? TIME_MAX : t;
            pid = ($urandom_range(99) < 85) ? pool[$urandom_range(pool.size() - 1, 0)]
                                            : PID_W'($urandom);
            ts = TIME_W'(clock_ts);
            // occasional out-of-order timestamp
            if ($urandom_range(99) < 3) begin
                back = $urandom_range(32'(span), 0) + 1;
                ts = (clock_ts > back) ? TIME_W'(clock_ts - back) : '0;
            end
            push_event(pid, 1'($urandom), ts);
        end
    endtask

    // Sample handshakes, predict accepted events, check results
    always @(posedge clk) begin
        t_outcome want;
        t_outcome pred;
        if (rst_n) begin
            evt_took = evt.valid && evt.ready;
            cfg_took = cfg.valid && cfg.ready;
            if (cfg_took) ivl_model = cfg.data;
            if (evt_took) begin
                pred = dedup_predict(evt.partner_id, evt.event_kind, evt.timestamp);
                outcome_q = {outcome_q, pred};
                n_sent++;
            end
            if (res.valid && res.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transaction with no outcome pending");
                    n_errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (res.accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, res.accepted);
                        n_errors++;
                    end
                    if (res.insert_dropped !== want.insert_dropped) begin
                        $error("insert_dropped: expected %0b, got %0b",
                               want.insert_dropped, res.insert_dropped);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
        end
    end

    // Event and config driver; config waits until every outcome has arrived
    always @(negedge clk) begin
        logic nv_evt, nv_cfg;
        if (!rst_n) begin
            evt.valid <= 1'b0;
            cfg.valid <= 1'b0;
        end else begin
            nv_evt = evt.valid && !evt_took;
            nv_cfg = cfg.valid && !cfg_took;
            if (!nv_evt && !nv_cfg && stim_q.size() > 0) begin
                case (stim_q[0].op)
                    STIM_EVENT: begin
                        if ((n_sent >= STEADY_LO && n_sent < STEADY_HI) ||
                            $urandom_range(99) >= IDLE_PCT) begin
                            evt.partner_id <= stim_q[0].pid;
                            evt.event_kind <= stim_q[0].knd;
                            evt.timestamp  <= stim_q[0].ts;
                            nv_evt = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    STIM_CONFIG: begin
                        if (outcome_q.size() == 0) begin
                            cfg.data <= stim_q[0].ivl;
                            nv_cfg = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                endcase
            end
            evt.valid <= nv_evt;
            cfg.valid <= nv_cfg;
        end
    end

    // Result receiver: random stalls plus long hold-offs so the input backs up
    always @(negedge clk) begin
        if (!rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else if (n_sent >= next_hold) begin
            hold_left = HOLD_CYCLES;
            next_hold = (next_hold == HOLD_FIRST) ? HOLD_SECOND : 32'h7FFF_FFFF;
            res.ready <= 1'b0;
        end else begin
            res.ready <= (n_checked >= STEADY_LO && n_checked < STEADY_HI) ||
                         ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        evt.valid      = 1'b0;
        evt.partner_id = '0;
        evt.event_kind = 1'b0;
        evt.timestamp  = '0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        res.ready      = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            tbl_partner[k] = '0;
            tbl_kind[k]    = 1'b0;
            tbl_expiry[k]  = '0;
        end

        // Directed: new entry, duplicate, kind change, extreme ids
        push_event(16'h0000, 1'b0, 48'd0);
        push_event(16'h0000, 1'b0, 48'd1);
        push_event(16'h0000, 1'b1, 48'd2);
        push_event(16'hFFFF, 1'b1, 48'd3);
        // fill the list, then overflow it
        for (int k = 1; k <= 14; k++) push_event(PID_W'(k), 1'(k), 48'd10);
        push_event(16'h1234, 1'b0, 48'd20);
        // first entry expires exactly now: kept, list still full
        push_event(16'h1234, 1'b1, 48'd5000002);
        // two entries past expiry get removed, insert succeeds
        push_event(16'h1234, 1'b1, 48'd5000004);
        // zero interval: equal expiry kept, one tick later removed
        push_config('0);
        push_event(16'h0005, 1'b0, 48'd6000000);
        push_event(16'h0005, 1'b0, 48'd6000000);
        push_event(16'h0006, 1'b1, 48'd6000000);
        push_event(16'h0006, 1'b0, 48'd6000001);
        clock_ts = 64'd6000001;

        // Random phases over a spread of intervals
        gen_phase(32'd1, PHASE_ITEMS);
        gen_phase(32'd37, PHASE_ITEMS);
        gen_phase(32'd1000, PHASE_ITEMS);
        gen_phase(INTERVAL_W'($urandom_range(5000, 2)), PHASE_ITEMS);
        gen_phase(INTERVAL_W'($urandom), PHASE_ITEMS);
        gen_phase(32'hFFFF_FFFF, PHASE_ITEMS);
        gen_phase(EXPIRY_RESET, PHASE_ITEMS);

        // Near the top of time: expiry saturates
        clock_ts = TIME_MAX - (64'd1 << 33);
        gen_phase(32'hFFFF_FFFF, 30);
        push_event(16'hA5A5, 1'b1, TIME_W'(TIME_MAX));
        push_event(16'hA5A5, 1'b1, TIME_W'(TIME_MAX));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() > 0 || evt.valid || cfg.valid || outcome_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
